// ===== rtl/checkpointed_layer_stack_sorter_macros.svh =====
// Assertion macros for the checkpointed layer stack sorter.
// Used by the top level; no other dependencies.
`ifndef CHECKPOINTED_LAYER_STACK_SORTER_MACROS_SVH
`define CHECKPOINTED_LAYER_STACK_SORTER_MACROS_SVH

// same-cycle implication
`define CLSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CLSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/clss_pkg.sv =====
// Types and codes for the checkpointed layer stack sorter.
// No dependencies.
package clss_pkg;

   typedef enum logic [2:0] {
      OP_PUSH     = 3'd0,
      OP_MARK     = 3'd1,
      OP_ROLLBACK = 3'd2,
      OP_SET      = 3'd3,
      OP_SORT     = 3'd4,
      OP_READ     = 3'd5,
      OP_CLEAR    = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_LAYER_FULL = 3'd1,
      ST_CKPT_FULL  = 3'd2,
      ST_NO_CKPT    = 3'd3,
      ST_BAD_INDEX  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RMW,
      S_MARK_WR,
      S_RB_ADDR,
      S_RB_DATA,
      S_SORT_SEEK,
      S_SORT_IRD,
      S_SORT_JRD,
      S_SORT_SW1,
      S_SORT_SW2,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        mark;
      logic [15:0] score;
      logic [15:0] item;
   } entry_type;

endpackage

// ===== rtl/checkpointed_layer_stack_sorter.sv =====
// Checkpointed layer stacks with descending frame sort: top level and sequencer.
// Depends on clss_pkg, clss_ram and checkpointed_layer_stack_sorter_macros.svh.
//
//   channel | ports                                               | dir
//   req     | req_valid req_ready req_type req_layer_sel ...      | in
//   rsp     | rsp_valid rsp_ready rsp_item_out ... rsp_frame_depth | out
//
// Sort over n frame entries takes about n * n / 2 compare steps, each one read through
// the single read port of the entry RAM, plus layer seeks.
// Reset is synchronous; no clearing pass: every readable entry is pushed first.
// A finished result waits in the response register while the next is taken; FINISH stalls while it is held.
`include "checkpointed_layer_stack_sorter_macros.svh"

module checkpointed_layer_stack_sorter #(
   parameter int LAYERS          = 4,
   parameter int LAYER_DEPTH     = 256,
   parameter int MAX_CHECKPOINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [1:0]  req_layer_sel,
   input  logic [7:0]  req_slot_index,
   input  logic [15:0] req_item_in,
   input  logic signed [15:0] req_score_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_item_out,
   output logic signed [15:0] rsp_score_out,
   output logic        rsp_scored,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_frame_depth
);

   localparam int LW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int SW   = $clog2(LAYER_DEPTH + 1);
   localparam int CW   = $clog2(MAX_CHECKPOINTS + 1);
   localparam int ED   = LAYERS * LAYER_DEPTH;
   localparam int AW   = (ED > 1) ? $clog2(ED) : 1;
   localparam int CD   = MAX_CHECKPOINTS * LAYERS;
   localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
   localparam int EW   = $bits(clss_pkg::entry_type);

   clss_pkg::state_type  state_ff, state_in;

   logic [2:0]  rq_type_ff, rq_type_in;
   logic [1:0]  rq_layer_ff, rq_layer_in;
   logic [7:0]  rq_slot_ff, rq_slot_in;
   logic [15:0] rq_item_ff, rq_item_in;
   logic [15:0] rq_score_ff, rq_score_in;

   logic [SW-1:0] size_ff [LAYERS];
   logic [SW-1:0] size_in [LAYERS];
   logic [SW-1:0] base_ff [LAYERS];
   logic [SW-1:0] base_in [LAYERS];
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] lc_ff, lc_in;

   logic [LW-1:0] cl_ff, cl_in;
   logic [SW-1:0] cp_ff, cp_in;
   logic          from_base_ff, from_base_in;
   logic          inner_ff, inner_in;
   logic [LW-1:0] il_ff, il_in;
   logic [SW-1:0] ip_ff, ip_in;
   logic [AW-1:0] i_addr_ff, i_addr_in;
   logic [AW-1:0] best_addr_ff, best_addr_in;
   clss_pkg::entry_type best_ff, best_in;
   clss_pkg::entry_type ival_ff, ival_in;

   logic [15:0]          res_item_ff, res_item_in;
   logic [15:0]          res_score_ff, res_score_in;
   logic                 res_scored_ff, res_scored_in;
   clss_pkg::status_type res_status_ff, res_status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_item_ff, rsp_item_in;
   logic [15:0] rsp_score_ff, rsp_score_in;
   logic        rsp_scored_ff, rsp_scored_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_depth_ff, rsp_depth_in;

   logic                e_we;
   logic [AW-1:0]       e_waddr, e_raddr;
   clss_pkg::entry_type e_wdata, e_rdata;
   logic [EW-1:0]       e_rdata_raw;
   logic                c_we;
   logic [CAW-1:0]      c_waddr, c_raddr;
   logic [SW-1:0]       c_wdata, c_rdata;

   logic [LW-1:0] sel_layer;
   logic [SW-1:0] size_sel, base_sel;
   logic [LW-1:0] rq_layer_idx;
   logic          layer_ok, slot_ok, lc_last, cl_last, found, rsp_free;
   logic [SW-1:0] p_eff;
   logic [AW-1:0] req_addr, cur_addr, seek_addr;

   function automatic logic [AW-1:0] ent_addr(input logic [LW-1:0] l, input logic [SW-1:0] p);
      ent_addr = AW'(l) * AW'(LAYER_DEPTH) + AW'(p);
   endfunction

   function automatic logic ranks_above(input clss_pkg::entry_type a,
                                        input clss_pkg::entry_type b);
      ranks_above = a.mark && (!b.mark || ($signed(a.score) > $signed(b.score)));
   endfunction

   clss_ram #(.WIDTH(EW), .DEPTH(ED)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (EW'(e_wdata)),
      .rd_addr (e_raddr),
      .rd_data (e_rdata_raw)
   );
   assign e_rdata = clss_pkg::entry_type'(e_rdata_raw);

   clss_ram #(.WIDTH(SW), .DEPTH(CD)) u_ckpt_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   assign rq_layer_idx = LW'(rq_layer_ff);
   assign layer_ok     = (32'(rq_layer_ff) < LAYERS);
   assign lc_last      = (lc_ff == LW'(LAYERS - 1));
   assign cl_last      = (cl_ff == LW'(LAYERS - 1));
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sel_layer = rq_layer_idx;
      if (state_ff == clss_pkg::S_MARK_WR) begin
         sel_layer = lc_ff;
      end else if (state_ff == clss_pkg::S_SORT_SEEK) begin
         sel_layer = cl_ff;
      end
   end

   assign size_sel  = size_ff[sel_layer];
   assign base_sel  = base_ff[sel_layer];
   assign slot_ok   = layer_ok && (32'(rq_slot_ff) < 32'(size_sel));
   assign p_eff     = from_base_ff ? base_sel : cp_ff;
   assign found     = (p_eff < size_sel);
   assign req_addr  = ent_addr(rq_layer_idx, SW'(rq_slot_ff));
   assign cur_addr  = ent_addr(cl_ff, cp_ff);
   assign seek_addr = ent_addr(cl_ff, p_eff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clss_pkg::S_IDLE: begin
            if (req_valid) state_in = clss_pkg::S_DECODE;
         end
         clss_pkg::S_DECODE: begin
            state_in = clss_pkg::S_FINISH;
            unique case (clss_pkg::op_type'(rq_type_ff))
               clss_pkg::OP_MARK: begin
                  if (32'(count_ff) < MAX_CHECKPOINTS) state_in = clss_pkg::S_MARK_WR;
               end
               clss_pkg::OP_ROLLBACK: begin
                  if (count_ff > CW'(1)) state_in = clss_pkg::S_RB_ADDR;
               end
               clss_pkg::OP_SET, clss_pkg::OP_READ: begin
                  if (slot_ok) state_in = clss_pkg::S_RMW;
               end
               clss_pkg::OP_SORT: state_in = clss_pkg::S_SORT_SEEK;
               default: state_in = clss_pkg::S_FINISH;
            endcase
         end
         clss_pkg::S_RMW:     state_in = clss_pkg::S_FINISH;
         clss_pkg::S_MARK_WR: begin
            if (lc_last) state_in = clss_pkg::S_FINISH;
         end
         clss_pkg::S_RB_ADDR: state_in = clss_pkg::S_RB_DATA;
         clss_pkg::S_RB_DATA: begin
            state_in = lc_last ? clss_pkg::S_FINISH : clss_pkg::S_RB_ADDR;
         end
         clss_pkg::S_SORT_SEEK: begin
            if (found) begin
               state_in = inner_ff ? clss_pkg::S_SORT_JRD : clss_pkg::S_SORT_IRD;
            end else if (cl_last) begin
               if (!inner_ff) state_in = clss_pkg::S_FINISH;
               else if (best_addr_ff != i_addr_ff) state_in = clss_pkg::S_SORT_SW1;
            end
         end
         clss_pkg::S_SORT_IRD: state_in = clss_pkg::S_SORT_SEEK;
         clss_pkg::S_SORT_JRD: state_in = clss_pkg::S_SORT_SEEK;
         clss_pkg::S_SORT_SW1: state_in = clss_pkg::S_SORT_SW2;
         clss_pkg::S_SORT_SW2: state_in = clss_pkg::S_SORT_SEEK;
         clss_pkg::S_FINISH: begin
            if (rsp_free) state_in = clss_pkg::S_IDLE;
         end
         default: state_in = clss_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      rq_type_in    = rq_type_ff;
      rq_layer_in   = rq_layer_ff;
      rq_slot_in    = rq_slot_ff;
      rq_item_in    = rq_item_ff;
      rq_score_in   = rq_score_ff;
      size_in       = size_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      lc_in         = lc_ff;
      cl_in         = cl_ff;
      cp_in         = cp_ff;
      from_base_in  = from_base_ff;
      inner_in      = inner_ff;
      il_in         = il_ff;
      ip_in         = ip_ff;
      i_addr_in     = i_addr_ff;
      best_addr_in  = best_addr_ff;
      best_in       = best_ff;
      ival_in       = ival_ff;
      res_item_in   = res_item_ff;
      res_score_in  = res_score_ff;
      res_scored_in = res_scored_ff;
      res_status_in = res_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_scored_in = rsp_scored_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      e_we          = 1'b0;
      e_waddr       = req_addr;
      e_wdata       = '0;
      e_raddr       = req_addr;
      c_we          = 1'b0;
      c_waddr       = CAW'(count_ff) * CAW'(LAYERS) + CAW'(lc_ff);
      c_wdata       = size_sel;
      c_raddr       = CAW'(count_ff - CW'(1)) * CAW'(LAYERS) + CAW'(lc_ff);
      req_ready     = (state_ff == clss_pkg::S_IDLE);

      unique case (state_ff)
         clss_pkg::S_IDLE: begin
            rq_type_in  = req_type;
            rq_layer_in = req_layer_sel;
            rq_slot_in  = req_slot_index;
            rq_item_in  = req_item_in;
            rq_score_in = req_score_in;
         end
         clss_pkg::S_DECODE: begin
            res_item_in   = '0;
            res_score_in  = '0;
            res_scored_in = 1'b0;
            res_status_in = clss_pkg::ST_OK;
            lc_in         = '0;
            unique case (clss_pkg::op_type'(rq_type_ff))
               clss_pkg::OP_PUSH: begin
                  if (!layer_ok) begin
                     res_status_in = clss_pkg::ST_BAD_INDEX;
                  end else if (32'(size_sel) >= LAYER_DEPTH) begin
                     res_status_in = clss_pkg::ST_LAYER_FULL;
                  end else begin
                     e_we                  = 1'b1;
                     e_waddr               = ent_addr(rq_layer_idx, size_sel);
                     e_wdata.mark          = 1'b0;
                     e_wdata.score         = '0;
                     e_wdata.item          = rq_item_ff;
                     size_in[rq_layer_idx] = size_sel + SW'(1);
                  end
               end
               clss_pkg::OP_MARK: begin
                  if (32'(count_ff) >= MAX_CHECKPOINTS) begin
                     res_status_in = clss_pkg::ST_CKPT_FULL;
                  end else begin
                     base_in = size_ff;
                  end
               end
               clss_pkg::OP_ROLLBACK: begin
                  if (count_ff == '0) begin
                     res_status_in = clss_pkg::ST_NO_CKPT;
                  end else begin
                     size_in  = base_ff;
                     count_in = count_ff - CW'(1);
                     if (count_ff == CW'(1)) begin
                        for (int l = 0; l < LAYERS; l++) base_in[l] = '0;
                     end
                  end
               end
               clss_pkg::OP_SET, clss_pkg::OP_READ: begin
                  if (!slot_ok) res_status_in = clss_pkg::ST_BAD_INDEX;
               end
               clss_pkg::OP_SORT: begin
                  cl_in        = '0;
                  cp_in        = '0;
                  from_base_in = 1'b1;
                  inner_in     = 1'b0;
               end
               clss_pkg::OP_CLEAR: begin
                  count_in = '0;
                  for (int l = 0; l < LAYERS; l++) begin
                     size_in[l] = '0;
                     base_in[l] = '0;
                  end
               end
               default: res_status_in = clss_pkg::ST_OK;
            endcase
         end
         clss_pkg::S_RMW: begin
            if (clss_pkg::op_type'(rq_type_ff) == clss_pkg::OP_SET) begin
               e_we          = 1'b1;
               e_wdata.mark  = 1'b1;
               e_wdata.score = rq_score_ff;
               e_wdata.item  = e_rdata.item;
            end else begin
               res_item_in   = e_rdata.item;
               res_score_in  = e_rdata.mark ? e_rdata.score : 16'd0;
               res_scored_in = e_rdata.mark;
            end
         end
         clss_pkg::S_MARK_WR: begin
            c_we  = 1'b1;
            lc_in = LW'(lc_ff + 1'b1);
            if (lc_last) count_in = count_ff + CW'(1);
         end
         clss_pkg::S_RB_ADDR: begin
            lc_in = lc_ff;
         end
         clss_pkg::S_RB_DATA: begin
            base_in[lc_ff] = c_rdata;
            lc_in          = LW'(lc_ff + 1'b1);
         end
         clss_pkg::S_SORT_SEEK: begin
            e_raddr = seek_addr;
            if (found) begin
               cp_in = p_eff;
               if (!inner_ff) begin
                  il_in     = cl_ff;
                  ip_in     = p_eff;
                  i_addr_in = seek_addr;
               end
            end else if (!cl_last) begin
               cl_in        = LW'(cl_ff + 1'b1);
               from_base_in = 1'b1;
            end else if (inner_ff && (best_addr_ff == i_addr_ff)) begin
               cl_in        = il_ff;
               cp_in        = ip_ff + SW'(1);
               from_base_in = 1'b0;
               inner_in     = 1'b0;
            end
         end
         clss_pkg::S_SORT_IRD: begin
            best_in      = e_rdata;
            ival_in      = e_rdata;
            best_addr_in = i_addr_ff;
            cp_in        = cp_ff + SW'(1);
            from_base_in = 1'b0;
            inner_in     = 1'b1;
         end
         clss_pkg::S_SORT_JRD: begin
            if (ranks_above(e_rdata, best_ff)) begin
               best_in      = e_rdata;
               best_addr_in = cur_addr;
            end
            cp_in        = cp_ff + SW'(1);
            from_base_in = 1'b0;
         end
         clss_pkg::S_SORT_SW1: begin
            e_we    = 1'b1;
            e_waddr = i_addr_ff;
            e_wdata = best_ff;
         end
         clss_pkg::S_SORT_SW2: begin
            e_we         = 1'b1;
            e_waddr      = best_addr_ff;
            e_wdata      = ival_ff;
            cl_in        = il_ff;
            cp_in        = ip_ff + SW'(1);
            from_base_in = 1'b0;
            inner_in     = 1'b0;
         end
         clss_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = res_item_ff;
               rsp_score_in  = res_score_ff;
               rsp_scored_in = res_scored_ff;
               rsp_status_in = res_status_ff;
               rsp_depth_in  = 7'(count_ff);
            end
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clss_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LAYERS; l++) begin
            size_ff[l] <= '0;
            base_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_type_ff    <= rq_type_in;
      rq_layer_ff   <= rq_layer_in;
      rq_slot_ff    <= rq_slot_in;
      rq_item_ff    <= rq_item_in;
      rq_score_ff   <= rq_score_in;
      lc_ff         <= lc_in;
      cl_ff         <= cl_in;
      cp_ff         <= cp_in;
      from_base_ff  <= from_base_in;
      inner_ff      <= inner_in;
      il_ff         <= il_in;
      ip_ff         <= ip_in;
      i_addr_ff     <= i_addr_in;
      best_addr_ff  <= best_addr_in;
      best_ff       <= best_in;
      ival_ff       <= ival_in;
      res_item_ff   <= res_item_in;
      res_score_ff  <= res_score_in;
      res_scored_ff <= res_scored_in;
      res_status_ff <= res_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_scored_ff <= rsp_scored_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_out    = rsp_item_ff;
   assign rsp_score_out   = rsp_score_ff;
   assign rsp_scored      = rsp_scored_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_depth = rsp_depth_ff;

   `CLSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CLSS_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, 32'(count_ff) <= MAX_CHECKPOINTS)
   `CLSS_ASSERT_NOW(a_error_unscored, clock, reset, rsp_valid && (rsp_status != clss_pkg::ST_OK), !rsp_scored)

endmodule

// ===== rtl/clss_ram.sv =====
// Simple dual-port RAM with registered read data.
// No dependencies; used for the entry store and the checkpoint store.
module clss_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
